// ----- design/damped_sine_note_mixer_macros.svh -----
// ----------------------------------------------------------------------------
// damped sine note mixer assertion macros
// shared property shorthands, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef DAMPED_SINE_NOTE_MIXER_MACROS_SVH
`define DAMPED_SINE_NOTE_MIXER_MACROS_SVH

// same-cycle implication
`define DSNM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSNM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dsnm_pkg.sv -----
// ----------------------------------------------------------------------------
// dsnm_pkg
// types, codes and the sine table generator of the damped sine note mixer
// ----------------------------------------------------------------------------
`default_nettype none

package dsnm_pkg;

  localparam int unsigned ENV_W    = 32;
  localparam int unsigned POS_W    = 24;
  localparam int unsigned SAMPLE_W = 20;
  localparam int unsigned SINE_W   = 16;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned CFG_W    = 2;
  localparam int unsigned NIDX_W   = 4;

  localparam logic [POS_W-1:0] POS_MAX     = '1;
  localparam logic [31:0]      HALF_PI_Q30 = 32'd1686629713;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_NOTE = 1'b1;

  localparam logic [CFG_W-1:0] CFG_NOTE_COUNT  = 2'd0;
  localparam logic [CFG_W-1:0] CFG_PLAY_LENGTH = 2'd1;
  localparam logic [CFG_W-1:0] CFG_ENV_FLOOR   = 2'd2;

  localparam logic [CNT_W-1:0] RST_NOTE_COUNT  = 5'd0;
  localparam logic [POS_W-1:0] RST_PLAY_LENGTH = 24'd396900;
  localparam logic [ENV_W-1:0] RST_ENV_FLOOR   = 32'd4295;

  typedef logic signed [SINE_W-1:0] sine_t;

  typedef struct packed {
    logic [ENV_W-1:0] env;
    logic [ENV_W-1:0] decay;
    logic [ENV_W-1:0] step;
    logic [POS_W-1:0] start;
    logic [ENV_W-1:0] phase;
  } note_row_t;

  // quarter-wave taylor series through x^13, mirrored by quadrant
  function automatic sine_t sine_entry(input int unsigned k, input int unsigned addr_bits);
    int unsigned        qb;
    logic [1:0]         quad;
    logic [63:0]        j;
    logic [63:0]        th;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] acc;
    qb   = addr_bits - 2;
    quad = 2'((k >> qb) & 32'd3);
    j    = 64'(k & ((32'd1 << qb) - 32'd1));
    if (quad[0]) j = (64'd1 << qb) - j;
    th   = (j * 64'(HALF_PI_Q30)) >> qb;
    x2   = (th * th) >> 30;
    acc  = $signed(th);
    term = ((th * x2) >> 30) / 64'd6;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + $signed(term);
    if (acc < 0) acc = '0;
    v = ($unsigned(acc) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return quad[1] ? -$signed(v[SINE_W-1:0]) : $signed(v[SINE_W-1:0]);
  endfunction

endpackage

`default_nettype wire

// ----- design/dsnm_note_ram.sv -----
// ----------------------------------------------------------------------------
// dsnm_note_ram
// per-note state memory, one row per slot, registered read, row valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module dsnm_note_ram #(
  parameter int unsigned NOTES = 16,
  parameter int unsigned IDX_W = 4
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       wr_en_i,
  input  wire  [IDX_W-1:0]          wr_addr_i,
  input  wire  dsnm_pkg::note_row_t wr_row_i,
  input  wire                       rd_en_i,
  input  wire  [IDX_W-1:0]          rd_addr_i,
  output dsnm_pkg::note_row_t       rd_row_o,
  output logic                      rd_valid_o
);
  import dsnm_pkg::*;

  note_row_t        mem [NOTES];
  logic [NOTES-1:0] valid_q;
  note_row_t        rd_row_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_row_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // unwritten rows read with zero envelope and phase
  always_comb begin
    rd_row_o = rd_row_q;
    if (!rd_valid_q) begin
      rd_row_o.env   = '0;
      rd_row_o.phase = '0;
    end
  end

  assign rd_valid_o = rd_valid_q;

endmodule

`default_nettype wire

// ----- design/dsnm_sine_rom.sv -----
// ----------------------------------------------------------------------------
// dsnm_sine_rom
// full-wave q1.15 sine table with a registered read
// ----------------------------------------------------------------------------
`default_nettype none

module dsnm_sine_rom #(
  parameter int unsigned ADDR_BITS = 10
) (
  input  wire                   clk_i,
  input  wire                   rd_en_i,
  input  wire  [ADDR_BITS-1:0]  rd_addr_i,
  output dsnm_pkg::sine_t       rd_data_o
);
  import dsnm_pkg::*;

  localparam int unsigned SIZE = 1 << ADDR_BITS;

  sine_t tab [SIZE];
  sine_t rd_data_q;

  for (genvar g = 0; g < SIZE; g++) begin : g_tab
    assign tab[g] = sine_entry(g, ADDR_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= tab[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- design/damped_sine_note_mixer.sv -----
// ----------------------------------------------------------------------------
// damped_sine_note_mixer
// additive mix of decaying sinusoids held in a note memory, one sample a tick
// ----------------------------------------------------------------------------
// channel   dir  tdata / tuser / tlast
// s_axis    in   tdata: note_index, start_amplitude, decay_factor, phase_step,
//                start_sample, zero pad; tuser: opcode
// m_axis    out  tdata: sample, zero pad; tlast: last
// cfg       in   cfg_we_i / cfg_addr_i / cfg_wdata_i, one register per write
//
// a tick issues one note memory read per slot, three stages behind it, then the
// output load; a note write does a phase multiply then a row write. reset clears
// control, valid bits of the note memory and the sample position, and loads the
// register defaults. a stalled output holds the next tick at its last step, and
// the input stays closed until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module damped_sine_note_mixer #(
  parameter int unsigned NOTES          = 16,
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // note_index, start_amplitude, decay_factor, phase_step, start_sample, pad
  input  wire  [127:0] s_axis_tdata,
  // opcode
  input  wire  [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // sample, pad
  output logic [23:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_addr_i,
  input  wire  [31:0]  cfg_wdata_i
);
  import dsnm_pkg::*;
  `include "damped_sine_note_mixer_macros.svh"

  localparam int unsigned IDX_W = (NOTES > 1) ? $clog2(NOTES) : 1;
  localparam int unsigned CMP_W = IDX_W + CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTES - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_NW_MUL = 3'd1;
  localparam logic [2:0] ST_NW_WR  = 3'd2;
  localparam logic [2:0] ST_TICK   = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0] state_q, state_d;

  logic [CNT_W-1:0] note_count_q;
  logic [POS_W-1:0] play_len_q;
  logic [ENV_W-1:0] floor_q;
  logic [POS_W-1:0] pos_q;

  // input fields
  logic [NIDX_W-1:0] in_idx;
  logic [ENV_W-1:0]  in_amp, in_decay, in_step;
  logic [POS_W-1:0]  in_start;
  logic              in_xfer;

  assign in_idx   = s_axis_tdata[3:0];
  assign in_amp   = s_axis_tdata[35:4];
  assign in_decay = s_axis_tdata[67:36];
  assign in_step  = s_axis_tdata[99:68];
  assign in_start = s_axis_tdata[123:100];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // note write holding registers
  logic [IDX_W-1:0] nw_idx_q;
  logic [ENV_W-1:0] nw_amp_q, nw_decay_q, nw_step_q, nw_phase_q;
  logic [POS_W-1:0] nw_start_q;
  logic [55:0]      nw_prod;

  assign nw_prod = nw_step_q * pos_q;

  // slot issue
  logic             iss_on_q;
  logic [IDX_W-1:0] iss_idx_q;
  logic             rd_en;

  assign rd_en = (state_q == ST_TICK) && iss_on_q;

  // stage 1: memory data
  note_row_t        s1_row;
  logic             s1_rv;
  logic             s1_vld_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s1_active, s1_live, s1_en;
  logic [63:0]      dec_prod;
  logic [ENV_W-1:0] s1_env_new;

  // stage 2: decayed envelope, sine value
  logic             s2_vld_q, s2_wb_q, s2_en_q, s2_last_q;
  logic [IDX_W-1:0] s2_idx_q;
  logic [ENV_W-1:0] s2_env_q, s2_env_new_q, s2_phase_new_q, s2_decay_q, s2_step_q;
  logic [POS_W-1:0] s2_start_q;
  sine_t            sine;
  logic signed [48:0] cprod;

  // stage 3: contribution
  logic                s3_vld_q, s3_en_q, s3_last_q;
  logic [SAMPLE_W-1:0] contrib_q;
  logic [SAMPLE_W-1:0] sum_q;

  // memory write port
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  note_row_t        wr_row;

  // output register
  logic                m_vld_q, m_last_q, out_load;
  logic [SAMPLE_W-1:0] m_sample_q;
  logic [POS_W-1:0]    pos_next;

  dsnm_note_ram #(
    .NOTES (NOTES),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_row_i   (wr_row),
    .rd_en_i    (rd_en),
    .rd_addr_i  (iss_idx_q),
    .rd_row_o   (s1_row),
    .rd_valid_o (s1_rv)
  );

  dsnm_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk_i     (clk_i),
    .rd_en_i   (s1_vld_q),
    .rd_addr_i (s1_row.phase[ENV_W-1 -: SINE_ADDR_BITS]),
    .rd_data_o (sine)
  );

  assign s1_active  = CMP_W'(s1_idx_q) < CMP_W'(note_count_q);
  assign s1_live    = s1_rv && s1_active && (s1_row.start <= pos_q);
  assign s1_en      = s1_live && (s1_row.env >= floor_q);
  assign dec_prod   = s1_row.env * s1_row.decay;
  assign s1_env_new = s1_live ? dec_prod[63:32] : s1_row.env;

  assign cprod = $signed({1'b0, s2_env_q}) * sine;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s2_idx_q;
    wr_row  = '{env: s2_env_new_q, decay: s2_decay_q, step: s2_step_q,
                start: s2_start_q, phase: s2_phase_new_q};
    if (state_q == ST_NW_WR) begin
      wr_en   = 1'b1;
      wr_addr = nw_idx_q;
      wr_row  = '{env: nw_amp_q, decay: nw_decay_q, step: nw_step_q,
                  start: nw_start_q, phase: nw_phase_q};
    end else if (s2_vld_q && s2_wb_q) begin
      wr_en = 1'b1;
    end
  end

  assign pos_next = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;
  assign out_load = (state_q == ST_FIN) && (!m_vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser[0] == OP_TICK) begin
            state_d = ST_TICK;
          end else if (32'(in_idx) < NOTES) begin
            state_d = ST_NW_MUL;
          end
        end
      end
      ST_NW_MUL: state_d = ST_NW_WR;
      ST_NW_WR:  state_d = ST_IDLE;
      ST_TICK: begin
        if (s3_vld_q && s3_last_q) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      note_count_q <= RST_NOTE_COUNT;
      play_len_q   <= RST_PLAY_LENGTH;
      floor_q      <= RST_ENV_FLOOR;
      pos_q        <= '0;
      iss_on_q     <= 1'b0;
      iss_idx_q    <= '0;
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      s3_vld_q     <= 1'b0;
      m_vld_q      <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= rd_en;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_NOTE_COUNT:  note_count_q <= cfg_wdata_i[CNT_W-1:0];
          CFG_PLAY_LENGTH: play_len_q   <= cfg_wdata_i[POS_W-1:0];
          CFG_ENV_FLOOR:   floor_q      <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_xfer && (s_axis_tuser[0] == OP_TICK)) begin
        iss_on_q  <= 1'b1;
        iss_idx_q <= '0;
      end else if (rd_en) begin
        if (iss_idx_q == LAST_IDX) begin
          iss_on_q <= 1'b0;
        end else begin
          iss_idx_q <= iss_idx_q + 1'b1;
        end
      end
      if (out_load) begin
        m_vld_q <= 1'b1;
        pos_q   <= pos_next;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      nw_idx_q   <= IDX_W'(in_idx);
      nw_amp_q   <= in_amp;
      nw_decay_q <= in_decay;
      nw_step_q  <= in_step;
      nw_start_q <= in_start;
    end
    if (state_q == ST_NW_MUL) begin
      nw_phase_q <= nw_prod[ENV_W-1:0];
    end
    s1_idx_q       <= iss_idx_q;
    s2_idx_q       <= s1_idx_q;
    s2_last_q      <= (s1_idx_q == LAST_IDX);
    s2_wb_q        <= s1_rv;
    s2_en_q        <= s1_en;
    s2_env_q       <= s1_row.env;
    s2_env_new_q   <= s1_env_new;
    s2_phase_new_q <= s1_row.phase + s1_row.step;
    s2_decay_q     <= s1_row.decay;
    s2_step_q      <= s1_row.step;
    s2_start_q     <= s1_row.start;
    s3_en_q        <= s2_en_q;
    s3_last_q      <= s2_last_q;
    contrib_q      <= {{(SAMPLE_W-17){cprod[48]}}, cprod[48:32]};
    if (in_xfer) begin
      sum_q <= '0;
    end else if (s3_vld_q && s3_en_q) begin
      sum_q <= sum_q + contrib_q;
    end
    if (out_load) begin
      m_sample_q <= sum_q;
      m_last_q   <= (pos_next >= play_len_q);
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {4'b0, m_sample_q};
  assign m_axis_tlast  = m_last_q;

  `DSNM_ASSERT_NXT(a_last_slot_fin, s3_vld_q && s3_last_q, state_q == ST_FIN,
                   "last slot did not end the tick")
  `DSNM_ASSERT_IMP(a_idle_pipe_empty, state_q == ST_IDLE,
                   !s1_vld_q && !s2_vld_q && !s3_vld_q,
                   "slot pipeline busy while idle")
  `DSNM_ASSERT_IMP(a_out_from_fin, $rose(m_vld_q), $past(state_q == ST_FIN),
                   "output raised outside the tick end")
  `DSNM_ASSERT_NXT(a_pos_step, out_load && (pos_q != POS_MAX), pos_q == $past(pos_q) + 1'b1,
                   "sample position did not advance")
  `DSNM_ASSERT_IMP(a_wr_owner, s2_vld_q && s2_wb_q, state_q == ST_TICK,
                   "slot write back outside a tick")

endmodule

`default_nettype wire

// ----- tb/sv/damped_sine_note_mixer_tb.sv -----
// ----------------------------------------------------------------------------
// damped_sine_note_mixer_tb
// note writes, sample ticks and idle register writes into the mixer, with a
// scoreboard that models the note memory and checks every output transfer
// ----------------------------------------------------------------------------
module damped_sine_note_mixer_tb;
  import dsnm_pkg::*;

  localparam int unsigned NOTES        = 16;
  localparam int unsigned ADDR_BITS    = 10;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS  = 135;
  localparam int unsigned PHASES       = 7;

  typedef struct {
    logic        opcode;
    logic [3:0]  slot;
    logic [31:0] amplitude;
    logic [31:0] decay;
    logic [31:0] phase_inc;
    logic [23:0] start;
  } note_item_t;

  typedef struct {
    logic [19:0] sample;
    logic        last;
  } mix_result_t;

  class mix_scoreboard;
    bit [31:0]   env_q[NOTES];
    bit [31:0]   decay_q[NOTES];
    bit [31:0]   inc_q[NOTES];
    bit [23:0]   start_q[NOTES];
    bit [31:0]   phase_q[NOTES];
    bit [23:0]   position;
    bit [4:0]    voice_limit;
    bit [23:0]   last_at;
    bit [31:0]   floor_lvl;
    int          sine_q[1 << ADDR_BITS];
    mix_result_t expected_mix[$];
    int unsigned failures;

    function new();
      for (int k = 0; k < (1 << ADDR_BITS); k++) sine_q[k] = sine_value(k);
      for (int i = 0; i < NOTES; i++) begin
        env_q[i]   = '0;
        decay_q[i] = '0;
        inc_q[i]   = '0;
        start_q[i] = '0;
        phase_q[i] = '0;
      end
      position    = '0;
      voice_limit = RST_NOTE_COUNT;
      last_at     = RST_PLAY_LENGTH;
      floor_lvl   = RST_ENV_FLOOR;
      failures    = 0;
    endfunction

    // quarter-wave taylor series, q1.15, mirrored by quadrant
    function int sine_value(int unsigned k);
      longint unsigned quarter;
      longint unsigned j;
      longint unsigned th;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          acc;
      int unsigned     quad;
      quarter = longint'(1) << (ADDR_BITS - 2);
      quad    = 32'((k / quarter) % 4);
      j       = k % quarter;
      if (quad % 2 == 1) j = quarter - j;
      th   = (j * HALF_PI_Q30) / quarter;
      x2   = (th * th) >> 30;
      term = th;
      acc  = th;
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / longint'(4 * n * n + 2 * n);
        if (n % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      v = ($unsigned(acc) * 32767 + (longint'(1) << 29)) >> 30;
      if (v > 32767) v = 32767;
      return (quad >= 2) ? -int'(v) : int'(v);
    endfunction

    function int unsigned pending();
      return expected_mix.size();
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_NOTE_COUNT:  voice_limit = val[4:0];
        CFG_PLAY_LENGTH: last_at = val[23:0];
        CFG_ENV_FLOOR:   floor_lvl = val;
        default: ;
      endcase
    endfunction

    function void note_input(note_item_t it);
      int              sum;
      int unsigned     active;
      bit [9:0]        addr;
      longint          prod;
      longint unsigned wide;
      mix_result_t     res;
      if (it.opcode == OP_NOTE) begin
        env_q[it.slot]   = it.amplitude;
        decay_q[it.slot] = it.decay;
        inc_q[it.slot]   = it.phase_inc;
        start_q[it.slot] = it.start;
        // phase follows absolute time from sample zero
        phase_q[it.slot] = it.phase_inc * {8'b0, position};
        return;
      end
      sum    = 0;
      active = (voice_limit < NOTES) ? voice_limit : NOTES;
      for (int i = 0; i < NOTES; i++) begin
        if (i < active && start_q[i] <= position) begin
          if (env_q[i] >= floor_lvl) begin
            addr = phase_q[i][31 -: ADDR_BITS];
            prod = longint'(env_q[i]) * longint'(sine_q[addr]);
            sum += int'(prod >>> 32);
          end
          wide     = longint'(env_q[i]) * longint'(decay_q[i]);
          env_q[i] = wide[63:32];
        end
        phase_q[i] += inc_q[i];
      end
      if (position != POS_MAX) position++;
      res.sample = sum[19:0];
      res.last   = (position >= last_at);
      expected_mix.push_back(res);
    endfunction

    function void check_result(logic [19:0] got_sample, logic got_last);
      mix_result_t exp_res;
      if (expected_mix.size() == 0) begin
        $display("%0t: unexpected sample transfer, actual sample %0d last %0b",
                 $time, $signed(got_sample), got_last);
        failures++;
        return;
      end
      exp_res = expected_mix.pop_front();
      if (got_sample !== exp_res.sample) begin
        $display("%0t: sample mismatch, expected %0d, actual %0d",
                 $time, $signed(exp_res.sample), $signed(got_sample));
        failures++;
      end
      if (got_last !== exp_res.last) begin
        $display("%0t: last mismatch, expected %0b, actual %0b",
                 $time, exp_res.last, got_last);
        failures++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [23:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_we_i;
  logic [1:0]   cfg_addr_i;
  logic [31:0]  cfg_wdata_i;

  mix_scoreboard board;
  int unsigned   burst_left;
  int unsigned   rx_cycle;
  int unsigned   hold_ctr;
  logic          hold_low;

  damped_sine_note_mixer #(
    .NOTES         (NOTES),
    .SINE_ADDR_BITS(ADDR_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic note_item_t make_note(logic [3:0] slot, logic [31:0] amplitude,
                                           logic [31:0] decay, logic [31:0] phase_inc,
                                           logic [23:0] start);
    note_item_t it;
    it.opcode    = OP_NOTE;
    it.slot      = slot;
    it.amplitude = amplitude;
    it.decay     = decay;
    it.phase_inc = phase_inc;
    it.start     = start;
    return it;
  endfunction

  function automatic note_item_t make_tick();
    note_item_t it;
    it           = make_note(4'($urandom), $urandom, $urandom, $urandom, 24'($urandom));
    it.opcode    = OP_TICK;
    return it;
  endfunction

  // mostly ticks; notes mostly start near the current position and decay slowly
  function automatic note_item_t random_item();
    logic [31:0] amplitude;
    logic [31:0] decay;
    logic [23:0] start;
    if ($urandom_range(0, 3) != 0) return make_tick();
    case ($urandom_range(0, 5))
      0:       amplitude = '1;
      1:       amplitude = '0;
      default: amplitude = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0:       decay = $urandom;
      1:       decay = '1;
      default: decay = {8'hff, 24'($urandom)};
    endcase
    case ($urandom_range(0, 4))
      0:       start = '0;
      1:       start = 24'($urandom);
      default: start = board.position + 24'($urandom_range(0, 30));
    endcase
    return make_note(4'($urandom), amplitude, decay, $urandom, start);
  endfunction

  task automatic send_item(input note_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.opcode;
    s_axis_tdata  <= {4'b0, it.start, it.phase_inc, it.decay, it.amplitude, it.slot};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_register(idx, val);
  endtask

  // receiver: always ready, coin flip, one in four, long holds
  initial begin
    m_axis_tready = 1'b0;
    rx_cycle      = 0;
    hold_ctr      = 0;
    hold_low      = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      case ((rx_cycle / 300) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (rx_cycle % 4 == 0);
        default: begin
          if (hold_ctr != 0) begin
            hold_ctr--;
          end else begin
            hold_low = !hold_low;
            hold_ctr = hold_low ? $urandom_range(10, 40) : $urandom_range(1, 8);
          end
          m_axis_tready <= !hold_low;
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata[19:0], m_axis_tlast);
  end

  initial begin
    logic [4:0]  count_val;
    logic [23:0] length_val;
    logic [31:0] floor_val;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    burst_left    = 0;
    board         = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: every slot loaded before the first tick
    write_reg(CFG_NOTE_COUNT, 32'd16);
    write_reg(CFG_PLAY_LENGTH, 32'd3);
    write_reg(CFG_ENV_FLOOR, 32'd0);
    send_item(make_note(4'd0, '1, '1, 32'h4000_0000, 24'd0));
    send_item(make_note(4'd1, '1, '0, '1, 24'd0));
    send_item(make_note(4'd2, '0, '1, 32'h1234_5678, 24'd0));
    send_item(make_note(4'd3, 32'h8000_0000, '1, 32'h0040_0000, 24'hff_ffff));
    send_item(make_note(4'd4, '1, 32'hf000_0000, 32'h8000_0000, 24'd2));
    for (int s = 5; s < NOTES; s++)
      send_item(make_note(4'(s), $urandom, {8'hff, 24'($urandom)}, $urandom, 24'd0));
    repeat (3) send_item(make_tick());
    // rewrite after time has passed, phase taken from position
    send_item(make_note(4'd3, '1, 32'hffff_0000, 32'h0123_4567, 24'd4));
    repeat (2) send_item(make_tick());
    send_item(make_note(4'd15, 32'd1, '1, '1, 24'd0));
    drain();
    write_reg(CFG_ENV_FLOOR, '1);
    write_reg(CFG_PLAY_LENGTH, 32'd0);
    repeat (2) send_item(make_tick());
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          count_val  = 5'd16;
          length_val = 24'd1;
          floor_val  = '0;
        end
        1: begin
          count_val  = 5'd0;
          length_val = 24'd0;
          floor_val  = $urandom;
        end
        2: begin
          count_val  = 5'd31;
          length_val = '1;
          floor_val  = '1;
        end
        default: begin
          count_val  = 5'($urandom_range(1, 16));
          length_val = 24'($urandom_range(1, 400));
          case ($urandom_range(0, 3))
            0:       floor_val = '0;
            1:       floor_val = RST_ENV_FLOOR;
            2:       floor_val = $urandom_range(0, 1 << 26);
            default: floor_val = $urandom;
          endcase
        end
      endcase
      write_reg(CFG_NOTE_COUNT, {27'b0, count_val});
      write_reg(CFG_PLAY_LENGTH, {8'b0, length_val});
      write_reg(CFG_ENV_FLOOR, floor_val);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
      drain();
    end

    if (board.failures == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
